// ===== hw/rtl/dtip_pkg.sv =====
// ----------------------------------------------------------------------------
// dtip_pkg
// Types, codes and constants shared by the decimal text parser modules.
// ----------------------------------------------------------------------------
package dtip_pkg;

  // Default for the longest string the parser accepts, in characters.
  localparam int unsigned MaxCharsDefault = 11;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONVERT_LENGTH = 2'd0,
    CFG_IGNORE_ZERO    = 2'd1,
    CFG_NARROW_MODE    = 2'd2
  } cfg_idx_e;

  // Character codes.
  localparam logic [7:0] ChTerm  = 8'h00;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // The magnitude is held saturating just above the int32 range: any value
  // past the largest negative magnitude fails, so nothing more is needed.
  localparam int unsigned AccW = 33;
  localparam logic [AccW-1:0] AccSat = 33'h1_0000_0000;

  // Range limits on the magnitude of a positive result.
  localparam logic [AccW-1:0] LimWide   = 33'h0_7fff_ffff;
  localparam logic [AccW-1:0] LimNarrow = 33'h0_0000_7fff;

  // Parse phases, one-hot.
  typedef enum logic [5:0] {
    PH_START      = 6'b000001,
    PH_AFTER_SIGN = 6'b000010,
    PH_LEAD_ZERO  = 6'b000100,
    PH_ZEROS      = 6'b001000,
    PH_DIGITS     = 6'b010000,
    PH_WAIT       = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] convert_length;
    logic       ignore_zero;
    logic       narrow_mode;
  } cfg_t;

  typedef struct packed {
    phase_e          phase;
    logic [7:0]      position;
    logic            negative;
    logic [AccW-1:0] acc;
    logic            failed;
  } parse_t;

  localparam parse_t ParseReset = '{
    phase:    PH_START,
    position: 8'd0,
    negative: 1'b0,
    acc:      '0,
    failed:   1'b0
  };

endpackage

// ===== hw/rtl/dtip_step.sv =====
// ----------------------------------------------------------------------------
// dtip_step
// Next-state and result logic for one string byte of the decimal parser.
// ----------------------------------------------------------------------------
module dtip_step #(
  parameter int unsigned MaxChars = dtip_pkg::MaxCharsDefault
) (
  input  dtip_pkg::parse_t cur_i,
  input  dtip_pkg::cfg_t   cfg_i,
  input  logic [7:0]       ch_i,
  output dtip_pkg::parse_t nxt_o,
  output logic [31:0]      value_o,
  output logic             ok_o
);
  import dtip_pkg::*;

  logic            is_digit;
  logic [3:0]      digit;
  logic            early;
  logic            too_long;
  logic [AccW+3:0] acc_x10;
  logic [AccW-1:0] acc_step;
  logic            take_first;
  logic            good;
  logic [AccW-1:0] lim;

  assign is_digit = (ch_i >= ChZero) && (ch_i <= ChNine);
  assign digit    = 4'(ch_i - ChZero);
  assign early    = (cfg_i.convert_length != 8'd0) &&
                    (({1'b0, cur_i.position} + 9'd1) >= {1'b0, cfg_i.convert_length});
  assign too_long = cur_i.position >= 8'(MaxChars);

  // Times ten as shift and add, then clamp.
  assign acc_x10  = ({4'b0, cur_i.acc} << 3) + ({4'b0, cur_i.acc} << 1) +
                    {{AccW{1'b0}}, digit};
  assign acc_step = (acc_x10 > {4'b0, AccSat}) ? AccSat : acc_x10[AccW-1:0];

  always_comb begin
    nxt_o      = cur_i;
    take_first = 1'b0;
    if (cur_i.position != 8'hff) begin
      nxt_o.position = cur_i.position + 8'd1;
    end
    case (cur_i.phase)
      PH_START, PH_AFTER_SIGN: begin
        if (cur_i.phase == PH_START && ch_i == ChMinus) begin
          nxt_o.negative = 1'b1;
          nxt_o.phase    = PH_AFTER_SIGN;
        end else if (ch_i == ChZero) begin
          if (cfg_i.convert_length == 8'd1) begin
            nxt_o.acc   = '0;
            nxt_o.phase = PH_WAIT;
          end else begin
            nxt_o.phase = PH_LEAD_ZERO;
          end
        end else begin
          take_first = 1'b1;
        end
      end
      PH_LEAD_ZERO, PH_ZEROS: begin
        if ((cur_i.phase == PH_LEAD_ZERO && !cfg_i.ignore_zero) || too_long) begin
          nxt_o.failed = 1'b1;
          nxt_o.phase  = PH_WAIT;
        end else if (ch_i == ChZero) begin
          nxt_o.phase = PH_ZEROS;
        end else begin
          take_first = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (too_long || !is_digit) begin
          nxt_o.failed = 1'b1;
          nxt_o.phase  = PH_WAIT;
        end else begin
          nxt_o.acc = acc_step;
          if (early) begin
            nxt_o.phase = PH_WAIT;
          end
        end
      end
      default: ;
    endcase

    // First significant digit; accumulation may stop right on it.
    if (take_first) begin
      if (!is_digit) begin
        nxt_o.failed = 1'b1;
        nxt_o.phase  = PH_WAIT;
      end else begin
        nxt_o.acc   = {{(AccW-4){1'b0}}, digit};
        nxt_o.phase = early ? PH_WAIT : PH_DIGITS;
      end
    end
  end

  // Result for a terminator arriving in the current state.
  always_comb begin
    case (cur_i.phase)
      PH_LEAD_ZERO: good = 1'b1;
      PH_ZEROS:     good = !too_long;
      PH_DIGITS:    good = 1'b1;
      PH_WAIT:      good = !cur_i.failed;
      default:      good = 1'b0;
    endcase
  end

  assign lim  = (cfg_i.narrow_mode ? LimNarrow : LimWide) +
                {{(AccW-1){1'b0}}, cur_i.negative};
  assign ok_o = good && (cur_i.acc <= lim);

  always_comb begin
    if (!ok_o) begin
      value_o = '0;
    end else if (cur_i.negative) begin
      value_o = 32'd0 - cur_i.acc[31:0];
    end else begin
      value_o = cur_i.acc[31:0];
    end
  end

endmodule

// ===== hw/rtl/decimal_text_to_int_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_int_parser
// Parses a zero-terminated decimal string, one byte per beat, into a signed
// 32-bit value with a success flag.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+--------------------------
//   input    | in        | in_valid_i / in_ready_o   | ch_i (8 bits)
//   result   | out       | out_valid_o / out_ready_i | value_o (32 s), ok_o
//   config   | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte per cycle, save the terminator stall below: a single pass of the
// step logic updates the parse state. Only the terminator makes a result
// beat, registered and valid the cycle after it is accepted. Reset clears
// the parse state, the result valid flag and the config registers. Ordinary
// bytes go on while a result waits; only a new terminator stalls until
// out_ready_i takes the waiting beat. Config writes never stall.
// ----------------------------------------------------------------------------
module decimal_text_to_int_parser #(
  parameter int unsigned MaxChars = dtip_pkg::MaxCharsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     ch_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             value_o,
  output logic                           ok_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dtip_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);
  import dtip_pkg::*;

  // Configuration registers.
  cfg_t cfg_q;

  // Parse state carried from byte to byte.
  parse_t parse_q;
  parse_t parse_d;

  // Result register.
  logic        out_valid_q;
  logic [31:0] value_q;
  logic        ok_q;
  logic [31:0] step_value;
  logic        step_ok;

  logic in_fire;
  logic is_term;

  assign cfg_ready_o = 1'b1;

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CONVERT_LENGTH: cfg_q.convert_length <= cfg_data_i;
        CFG_IGNORE_ZERO:    cfg_q.ignore_zero    <= cfg_data_i[0];
        CFG_NARROW_MODE:    cfg_q.narrow_mode    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The terminator needs a free result slot; other bytes do not.
  assign is_term    = (ch_i == ChTerm);
  assign in_ready_o = !out_valid_q || out_ready_i || !is_term;
  assign in_fire    = in_valid_i && in_ready_o;

  dtip_step #(
    .MaxChars(MaxChars)
  ) u_step (
    .cur_i  (parse_q),
    .cfg_i  (cfg_q),
    .ch_i   (ch_i),
    .nxt_o  (parse_d),
    .value_o(step_value),
    .ok_o   (step_ok)
  );

  // Parse state: a terminator ends the string and starts a fresh one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= ParseReset;
    end else if (in_fire) begin
      parse_q <= is_term ? ParseReset : parse_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && is_term) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_term) begin
      value_q <= step_value;
      ok_q    <= step_ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign ok_o        = ok_q;

endmodule

// ===== tb/decimal_text_to_int_parser_test.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_int_parser_test
// Self-checking testbench for the decimal text parser. Strings go in one byte
// per beat with random gaps on both channels. A scoreboard class tracks the
// parse of each string on its own and checks every result beat against the
// oldest expected value. The run steps through several register settings.
// ----------------------------------------------------------------------------
module decimal_text_to_int_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dtip_pkg::*;

  localparam int unsigned MaxChars      = MaxCharsDefault;
  localparam int unsigned NumPhases     = 12;
  localparam int unsigned BytesPerPhase = 125;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned PressurePhase = 4;

  // Index 3 names no register; a write there must leave everything alone.
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  // Saturation point of the tracked magnitude, far above any legal result.
  localparam longint unsigned MagSat = 64'h40_0000_0000;

  typedef logic [7:0] text_q_t[$];

  // --------------------------------------------------------------------------
  // Scoreboard: follows the parse of the current string and queues the
  // number that each terminator must produce.
  // --------------------------------------------------------------------------
  class number_scoreboard;
    typedef struct {
      logic signed [31:0] value;
      logic               ok;
    } number_t;

    cfg_t            regs;
    phase_e          ph;
    int unsigned     pos;
    bit              neg;
    longint unsigned mag;
    bit              failed;
    number_t         expected_numbers[$];
    int unsigned     errors;

    function new();
      regs   = '0;
      errors = 0;
      restart_string();
    endfunction

    function void restart_string();
      ph     = PH_START;
      pos    = 0;
      neg    = 1'b0;
      mag    = 0;
      failed = 1'b0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= ChZero && c <= ChNine;
    endfunction

    function void give_up();
      failed = 1'b1;
      ph     = PH_WAIT;
    endfunction

    // The length limit stops accumulation once the covered characters reach it.
    function bit covered(int unsigned p);
      return regs.convert_length != 0 && p + 1 >= regs.convert_length;
    endfunction

    function void take_first(logic [7:0] c, int unsigned p);
      if (!is_digit(c)) begin
        give_up();
        return;
      end
      mag = c - ChZero;
      ph  = covered(p) ? PH_WAIT : PH_DIGITS;
    endfunction

    function void start_number(logic [7:0] c, int unsigned p);
      if (c == ChZero) begin
        if (regs.convert_length == 1) begin
          mag = 0;
          ph  = PH_WAIT;
        end else begin
          ph = PH_LEAD_ZERO;
        end
      end else begin
        take_first(c, p);
      end
    endfunction

    function void apply_reg_write(logic [CfgIdxW-1:0] idx, logic [7:0] data);
      case (idx)
        CFG_CONVERT_LENGTH: regs.convert_length = data;
        CFG_IGNORE_ZERO:    regs.ignore_zero    = data[0];
        CFG_NARROW_MODE:    regs.narrow_mode    = data[0];
        default: ;
      endcase
    endfunction

    // Advances the parse by one accepted byte; a terminator queues a number.
    function void parse_byte(logic [7:0] c);
      bit              good;
      longint unsigned lim;
      logic [63:0]     signed_val;
      number_t         n;

      if (c == ChTerm) begin
        case (ph)
          PH_LEAD_ZERO: good = 1'b1;
          PH_ZEROS:     good = pos <= MaxChars - 1;
          PH_DIGITS:    good = 1'b1;
          PH_WAIT:      good = !failed;
          default:      good = 1'b0;
        endcase
        lim = regs.narrow_mode ? 64'd32767 : 64'd2147483647;
        if (neg) lim = lim + 1;
        if (!good || mag > lim) begin
          n.value = '0;
          n.ok    = 1'b0;
        end else begin
          signed_val = neg ? (64'd0 - mag) : mag;
          n.value    = signed_val[31:0];
          n.ok       = 1'b1;
        end
        expected_numbers = {expected_numbers, n};
        restart_string();
        return;
      end

      case (ph)
        PH_START: begin
          if (c == ChMinus) begin
            neg = 1'b1;
            ph  = PH_AFTER_SIGN;
          end else begin
            start_number(c, pos);
          end
        end
        PH_AFTER_SIGN: start_number(c, pos);
        PH_LEAD_ZERO, PH_ZEROS: begin
          if (ph == PH_LEAD_ZERO && !regs.ignore_zero) begin
            give_up();
          end else if (pos > MaxChars - 1) begin
            give_up();
          end else if (c == ChZero) begin
            ph = PH_ZEROS;
          end else begin
            take_first(c, pos);
          end
        end
        PH_DIGITS: begin
          if (pos > MaxChars - 1 || !is_digit(c)) begin
            give_up();
          end else begin
            mag = mag * 10 + (c - ChZero);
            if (mag > MagSat) mag = MagSat;
            if (covered(pos)) ph = PH_WAIT;
          end
        end
        default: ;
      endcase

      if (pos < 255) pos++;
    endfunction

    function void check_result(logic signed [31:0] value, logic ok);
      number_t e;
      if (expected_numbers.size() == 0) begin
        $display("%0t: result beat with nothing expected: value=%0d ok=%0b",
                 $time, value, ok);
        errors++;
        return;
      end
      e = expected_numbers.pop_front();
      if (value !== e.value) begin
        $display("%0t: value mismatch: expected %0d, actual %0d", $time, e.value, value);
        errors++;
      end
      if (ok !== e.ok) begin
        $display("%0t: ok mismatch: expected %0b, actual %0b", $time, e.ok, ok);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_numbers.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test.
  // --------------------------------------------------------------------------
  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         ch_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] value_o;
  logic               ok_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [7:0]         cfg_data_i;

  decimal_text_to_int_parser #(
    .MaxChars(MaxChars)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .ok_o       (ok_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  number_scoreboard parse_check;
  bit               sender_idles;
  bit               receiver_idles;
  bit               hold_off_req;
  int unsigned      quiet_cycles;

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge. The result beat is
  // checked before the byte of the same edge is noted, because a terminator
  // accepted now cannot have its result out before the next edge.
  // The watchdog also lives here: it counts edges on which no channel moved.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_valid_o && out_ready_i) parse_check.check_result(value_o, ok_o);
      if (in_valid_i && in_ready_o) parse_check.parse_byte(ch_i);
      if (cfg_valid_i && cfg_ready_o) parse_check.apply_reg_write(cfg_index_i, cfg_data_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no beat on any channel for %0d cycles", $time, QuietLimit);
        $display("decimal_text_to_int_parser regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side. The ready line changes only at falling edges. Stalls come
  // at random while receiver idling is on; a requested hold-off keeps ready low
  // for a long stretch so that a second terminator backs up the input.
  // --------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i  = 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Each task is entered and left at a falling edge. A byte beat
  // leaves valid high so that the next byte follows without a bubble; the
  // caller lowers valid when it stops sending.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    ch_i       = c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_bytes(input text_q_t t);
    foreach (t[i]) send_byte(t[i]);
  endtask

  // Sends the characters of s followed by the terminator.
  task automatic send_text(input string s);
    text_q_t t;
    foreach (s[i]) t = {t, 8'(s[i])};
    t = {t, ChTerm};
    send_bytes(t);
  endtask

  task automatic drive_reg_write(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes all three registers. The one-bit registers get random upper data
  // bits, which must be dropped.
  task automatic apply_config(input logic [7:0] len, input logic iz, input logic nm);
    drive_reg_write(CFG_CONVERT_LENGTH, len);
    drive_reg_write(CFG_IGNORE_ZERO, {7'($urandom_range(0, 127)), iz});
    drive_reg_write(CFG_NARROW_MODE, {7'($urandom_range(0, 127)), nm});
    cfg_valid_i = 1'b0;
  endtask

  // Waits until every expected result is out, then a few cycles more so that
  // the parser is surely back at the start of a string.
  task automatic drain();
    in_valid_i = 1'b0;
    while (parse_check.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Random strings. Most are well-formed numbers (optional sign, optional
  // leading zeros, magnitudes of all sizes, some near int16 and int32 limits),
  // some of them with one byte corrupted. The rest are noise, runs of zeros
  // and overlong digit strings.
  // --------------------------------------------------------------------------
  function automatic text_q_t random_text();
    text_q_t         t;
    longint unsigned mag;
    string           digits;
    int unsigned     kind;
    int unsigned     spot;

    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      if ($urandom_range(0, 2) == 0) t = {t, ChMinus};
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) t = {t, ChZero};
      end
      case ($urandom_range(0, 5))
        0:       mag = $urandom_range(0, 999);
        1:       mag = $urandom_range(0, 99999);
        2:       mag = $urandom;
        3:       mag = 64'd2147483646 + $urandom_range(0, 3);
        4:       mag = 64'd32766 + $urandom_range(0, 3);
        default: mag = {$urandom, $urandom} % 64'd1_000_000_000_000;
      endcase
      digits = $sformatf("%0d", mag);
      foreach (digits[i]) t = {t, 8'(digits[i])};
      if (kind >= 60) begin
        spot    = $urandom_range(0, t.size() - 1);
        t[spot] = 8'($urandom_range(1, 255));
      end
    end else if (kind < 80) begin
      repeat ($urandom_range(0, 6)) t = {t, 8'($urandom_range(1, 255))};
    end else if (kind < 90) begin
      if ($urandom_range(0, 1) == 0) t = {t, ChMinus};
      repeat ($urandom_range(0, 13)) t = {t, ChZero};
      if ($urandom_range(0, 1) == 0) t = {t, 8'(ChZero + $urandom_range(1, 9))};
    end else begin
      if ($urandom_range(0, 1) == 0) t = {t, ChMinus};
      repeat ($urandom_range(MaxChars - 1, MaxChars + 3)) begin
        t = {t, 8'(ChZero + $urandom_range(0, 9))};
      end
    end
    t = {t, ChTerm};
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0]  len;
    logic        iz;
    logic        nm;
    int unsigned sent;
    text_q_t     t;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    ch_i           = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_CONVERT_LENGTH;
    cfg_data_i     = '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_off_req   = 1'b0;
    quiet_cycles   = 0;
    parse_check    = new();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the whole string converted, leading zeros rejected
    // and the int32 range: empty string, lone minus, negative zero, zero, a
    // rejected leading zero, the low end and one past the high end, a non-digit
    // with its top bit set. A write to the unused index must change nothing.
    drive_reg_write(CfgIdxUnused, 8'($urandom_range(0, 255)));
    apply_config(8'd0, 1'b0, 1'b0);
    send_text("");
    send_text("-");
    send_text("-0");
    send_text("0");
    send_text("07");
    send_text("-2147483648");
    send_text("2147483648");
    send_text("9\377");
    drain();

    // Random phases. The first six settings pin the extremes of the length
    // register together with every pairing of the two mode bits; the rest
    // are random with short lengths favored, since those cut strings early.
    for (int unsigned k = 0; k < NumPhases; k++) begin
      case (k)
        0: begin len = 8'd0;   iz = 1'b1; nm = 1'b0; end
        1: begin len = 8'd255; iz = 1'b0; nm = 1'b1; end
        2: begin len = 8'd1;   iz = 1'b1; nm = 1'b1; end
        3: begin len = 8'd1;   iz = 1'b0; nm = 1'b0; end
        4: begin len = 8'd0;   iz = 1'b0; nm = 1'b1; end
        5: begin len = 8'd2;   iz = 1'b1; nm = 1'b0; end
        default: begin
          len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, MaxChars + 1));
          iz  = 1'($urandom_range(0, 1));
          nm  = 1'($urandom_range(0, 1));
        end
      endcase
      apply_config(len, iz, nm);

      // The final phase runs with no idling on either side.
      if (k == NumPhases - 1) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end
      if (k == PressurePhase) hold_off_req = 1'b1;

      sent = 0;
      while (sent < BytesPerPhase) begin
        t = random_text();
        send_bytes(t);
        sent += t.size();
      end
      drain();
    end

    // Drain has already waited out the pipeline; a few more edges catch any
    // stray result beat.
    repeat (10) @(posedge clk_i);
    if (parse_check.errors == 0 && parse_check.pending() == 0) begin
      $display("decimal_text_to_int_parser regression: pass");
    end else begin
      $display("decimal_text_to_int_parser regression: fail");
    end
    $finish;
  end

endmodule
